// File: rtl/integer_to_ascii_formatter_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the integer to ASCII formatter
// Implication and next-cycle forms; compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_UNIT_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ITAF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("itaf assertion failed");

// next-cycle implication
`define ITAF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("itaf assertion failed");

`else

`define ITAF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ITAF_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/itaf_pkg.sv
// ----------------------------------------------------------------------------
// itaf_pkg
// Shared types, character constants and helpers of the integer formatter.
// ----------------------------------------------------------------------------
package itaf_pkg;

    // conversion selector codes
    localparam logic [2:0] FUNC_SDEC = 3'd0;
    localparam logic [2:0] FUNC_UDEC = 3'd1;
    localparam logic [2:0] FUNC_HEXL = 3'd2;
    localparam logic [2:0] FUNC_HEXU = 3'd3;
    localparam logic [2:0] FUNC_PTR  = 3'd4;

    localparam int unsigned COUNT_W = 31;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 31'h7FFF_FFFF;

    // ASCII codes used by the prefixes
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_I      = 8'h69;
    localparam logic [7:0] CH_L      = 8'h6C;

    localparam logic [7:0] HEX_LO [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66};
    localparam logic [7:0] HEX_UP [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46};

    // reciprocal of ten for the 32-bit digit step: q = (n * RECIP10) >> 35
    localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

    typedef enum logic [1:0] {
        PFX_NONE,
        PFX_MINUS,
        PFX_HEX,
        PFX_NIL
    } t_itaf_pfx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_PFX,
        S_DIG
    } t_itaf_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic conv_step;
        logic emit_pfx;
        logic emit_dig;
    } t_itaf_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_func_ok;
        logic in_nil;
        logic conv_done;
        logic has_pfx;
        logic pfx_last;
        logic is_nil;
        logic dig_last;
        logic out_free;
    } t_itaf_status;

    function automatic logic [2:0] pfx_len(t_itaf_pfx kind);
        logic [2:0] n;
        unique case (kind)
            PFX_NONE:  n = 3'd0;
            PFX_MINUS: n = 3'd1;
            PFX_HEX:   n = 3'd2;
            PFX_NIL:   n = 3'd5;
            default:   n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] pfx_char(t_itaf_pfx kind, logic [2:0] idx);
        logic [7:0] c;
        c = CH_ZERO;
        unique case (kind)
            PFX_MINUS: c = CH_MINUS;
            PFX_HEX:   c = (idx == 3'd0) ? CH_ZERO : CH_X;
            PFX_NIL: begin
                case (idx)
                    3'd0:    c = CH_LPAREN;
                    3'd1:    c = CH_N;
                    3'd2:    c = CH_I;
                    3'd3:    c = CH_L;
                    default: c = CH_RPAREN;
                endcase
            end
            default:   c = CH_ZERO;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/itaf_ctrl.sv
// ----------------------------------------------------------------------------
// itaf_ctrl
// Sequencer: load, digit conversion, prefix emission, digit emission.
// ----------------------------------------------------------------------------
`include "integer_to_ascii_formatter_unit_assert.svh"

module itaf_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  itaf_pkg::t_itaf_status i_status,
    output itaf_pkg::t_itaf_cmd   o_cmd
);

    itaf_pkg::t_itaf_state r_state;
    itaf_pkg::t_itaf_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= itaf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            itaf_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                // unused selectors are taken and dropped
                if (i_in_valid && i_status.in_func_ok) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.in_nil ? itaf_pkg::S_PFX : itaf_pkg::S_CONV;
                end
            end
            itaf_pkg::S_CONV: begin
                o_cmd.conv_step = 1'b1;
                if (i_status.conv_done) begin
                    n_state = i_status.has_pfx ? itaf_pkg::S_PFX : itaf_pkg::S_DIG;
                end
            end
            itaf_pkg::S_PFX: begin
                if (i_status.out_free) begin
                    o_cmd.emit_pfx = 1'b1;
                    if (i_status.pfx_last) begin
                        n_state = i_status.is_nil ? itaf_pkg::S_IDLE : itaf_pkg::S_DIG;
                    end
                end
            end
            itaf_pkg::S_DIG: begin
                if (i_status.out_free) begin
                    o_cmd.emit_dig = 1'b1;
                    if (i_status.dig_last) begin
                        n_state = itaf_pkg::S_IDLE;
                    end
                end
            end
            default: n_state = itaf_pkg::S_IDLE;
        endcase
    end

    // the final digit always hands control back to idle
    `ITAF_ASSERT_NXT(a_last_digit_idle, i_clk, i_rst_n, o_cmd.emit_dig && i_status.dig_last, r_state == itaf_pkg::S_IDLE)

endmodule

// File: rtl/itaf_datapath.sv
// ----------------------------------------------------------------------------
// itaf_datapath
// Operand decode, one-digit-per-cycle conversion, digit buffer, output register
// and saturating character count.
// ----------------------------------------------------------------------------
`include "integer_to_ascii_formatter_unit_assert.svh"

module itaf_datapath #(
    parameter int unsigned PTR_WIDTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [2:0]                    i_func,
    input  logic [63:0]                   i_value,
    input  itaf_pkg::t_itaf_cmd           i_cmd,
    output itaf_pkg::t_itaf_status        o_status,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [7:0]                    o_char,
    output logic                          o_last,
    output logic [itaf_pkg::COUNT_W-1:0]  o_count
);

    localparam logic [63:0] PTR_MASK = 64'({64{1'b1}} >> (64 - PTR_WIDTH));

    // working registers
    logic [63:0]          r_num;
    logic                 r_hex;
    logic                 r_upper;
    itaf_pkg::t_itaf_pfx  r_pfx;
    logic [2:0]           r_pfx_idx;
    logic [63:0]          r_dig;
    logic [3:0]           r_idx;

    // output register and count
    logic                          r_out_valid;
    logic [7:0]                    r_out_char;
    logic                          r_out_last;
    logic [itaf_pkg::COUNT_W-1:0]  r_count;

    // input decode
    logic                 in_ok;
    logic                 in_hex;
    logic                 in_upper;
    itaf_pkg::t_itaf_pfx  in_pfx;
    logic [63:0]          in_num;
    logic [31:0]          low;
    logic [31:0]          mag;
    logic [63:0]          ptr_val;

    always_comb begin
        low      = i_value[31:0];
        mag      = low[31] ? (~low + 32'd1) : low;
        ptr_val  = i_value & PTR_MASK;
        in_ok    = 1'b1;
        in_hex   = 1'b0;
        in_upper = 1'b0;
        in_pfx   = itaf_pkg::PFX_NONE;
        in_num   = {32'd0, low};
        unique case (i_func) inside
            itaf_pkg::FUNC_SDEC: begin
                in_num = {32'd0, mag};
                in_pfx = low[31] ? itaf_pkg::PFX_MINUS : itaf_pkg::PFX_NONE;
            end
            itaf_pkg::FUNC_UDEC: begin
                in_num = {32'd0, low};
            end
            itaf_pkg::FUNC_HEXL, itaf_pkg::FUNC_HEXU: begin
                in_hex   = 1'b1;
                in_upper = (i_func == itaf_pkg::FUNC_HEXU);
            end
            itaf_pkg::FUNC_PTR: begin
                in_hex = 1'b1;
                in_num = ptr_val;
                in_pfx = (ptr_val == 64'd0) ? itaf_pkg::PFX_NIL : itaf_pkg::PFX_HEX;
            end
            default: in_ok = 1'b0;
        endcase
    end

    // digit step: divide by ten through the reciprocal, or drop one nibble
    logic [63:0] prod;
    logic [28:0] quot;
    logic [31:0] quot10;
    logic [31:0] rem;
    logic [3:0]  digit;
    logic [63:0] num_next;

    always_comb begin
        prod     = r_num[31:0] * itaf_pkg::RECIP10;
        quot     = prod[63:35];
        quot10   = {quot, 3'b000} + {2'b00, quot, 1'b0};
        rem      = r_num[31:0] - quot10;
        digit    = r_hex ? r_num[3:0] : rem[3:0];
        num_next = r_hex ? {4'd0, r_num[63:4]} : {35'd0, quot};
    end

    // character selection; the most significant digit sits in the low nibble
    logic [3:0] cur_dig;
    logic [7:0] dig_char;
    logic [7:0] p_char;
    logic       pfx_last;
    logic       emit;

    always_comb begin
        cur_dig  = r_dig[3:0];
        dig_char = r_upper ? itaf_pkg::HEX_UP[cur_dig] : itaf_pkg::HEX_LO[cur_dig];
        p_char   = itaf_pkg::pfx_char(r_pfx, r_pfx_idx);
        pfx_last = (r_pfx_idx == (itaf_pkg::pfx_len(r_pfx) - 3'd1));
        emit     = i_cmd.emit_pfx || i_cmd.emit_dig;
    end

    // operand and digit buffer
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_num     <= in_num;
            r_hex     <= in_hex;
            r_upper   <= in_upper;
            r_pfx     <= in_pfx;
            r_pfx_idx <= 3'd0;
            r_idx     <= 4'hF;
        end else begin
            if (i_cmd.conv_step) begin
                r_num <= num_next;
                r_dig <= {r_dig[59:0], digit};
                r_idx <= r_idx + 4'd1;
            end
            if (i_cmd.emit_pfx) begin
                r_pfx_idx <= r_pfx_idx + 3'd1;
            end
            // next less significant digit moves down into the low nibble
            if (i_cmd.emit_dig) begin
                r_dig <= {4'd0, r_dig[63:4]};
                r_idx <= r_idx - 4'd1;
            end
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_char <= i_cmd.emit_pfx ? p_char : dig_char;
            r_out_last <= i_cmd.emit_pfx ? (pfx_last && (r_pfx == itaf_pkg::PFX_NIL))
                                         : (r_idx == 4'd0);
        end
    end

    // output valid and saturating count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
                if (r_count != itaf_pkg::COUNT_MAX) begin
                    r_count <= r_count + 31'd1;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status.in_func_ok = in_ok;
        o_status.in_nil     = (in_pfx == itaf_pkg::PFX_NIL);
        o_status.conv_done  = (num_next == 64'd0);
        o_status.has_pfx    = (r_pfx != itaf_pkg::PFX_NONE);
        o_status.pfx_last   = pfx_last;
        o_status.is_nil     = (r_pfx == itaf_pkg::PFX_NIL);
        o_status.dig_last   = (r_idx == 4'd0);
        o_status.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_char      = r_out_char;
    assign o_last      = r_out_last;
    assign o_count     = r_count;

    // a character is only pushed into a free output register
    `ITAF_ASSERT_IMP(a_emit_free, i_clk, i_rst_n, emit, !r_out_valid || i_out_ready)
    // count steps by one per character below saturation
    `ITAF_ASSERT_NXT(a_count_step, i_clk, i_rst_n, emit && (r_count != itaf_pkg::COUNT_MAX), r_count == $past(r_count) + 31'd1)
    // conversion and emission never overlap
    `ITAF_ASSERT_IMP(a_cmd_excl, i_clk, i_rst_n, i_cmd.conv_step, !emit && !i_cmd.load)

endmodule

// File: rtl/integer_to_ascii_formatter_unit.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_unit
// Formats one integer per request as ASCII text, one character per output
// request, with a saturating count of characters sent since reset.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                           | tuser     | tlast
//  s_axis  | in  | value[63:0]                     | func[2:0] | -
//  m_axis  | out | char_out[7:0], running_count    | -         | last
//
//  Per request: accept, convert D digits, send P prefix and then D digit
//  characters, D = number of digits (1..10 decimal, 1..8 hex, 1..PTR_WIDTH/4
//  pointer), P = 0, 1 ("-") or 2 ("0x"); "(nil)" sends its 5 characters only.
//  The divide-by-ten/nibble loop makes one digit per cycle and the single
//  output register one character per cycle while the output is not stalled.
//  Reset is synchronous, active low; it clears the count and the sequencer.
//  A stalled output holds the sequencer; no new input is taken mid-request.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_unit #(
    parameter int unsigned PTR_WIDTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] value
    input  logic [2:0]  s_axis_tuser,   // [2:0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] char_out, [38:8] running_count, [39] zero
    output logic        m_axis_tlast    // last
);

    itaf_pkg::t_itaf_cmd    cmd;
    itaf_pkg::t_itaf_status status;
    logic [7:0]                   out_char;
    logic [itaf_pkg::COUNT_W-1:0] out_count;

    itaf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    itaf_datapath #(
        .PTR_WIDTH (PTR_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_func      (s_axis_tuser),
        .i_value     (s_axis_tdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_char      (out_char),
        .o_last      (m_axis_tlast),
        .o_count     (out_count)
    );

    assign m_axis_tdata = {1'b0, out_count, out_char};

endmodule
